// File: rtl/core/dhcp_option_parser_core_assert.svh
// Assertion macros for the DHCP options parser core.
`ifndef DHCP_OPTION_PARSER_CORE_ASSERT_SVH
`define DHCP_OPTION_PARSER_CORE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DOP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dop: implication check failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DOP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dop: next-cycle check failed");
`else
`define DOP_ASSERT_IMP(lbl, ante, cons)
`define DOP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/dop_pkg.sv
// Types and constants shared by the DHCP options parser files.
package dop_pkg;

    localparam int NAME_BYTES = 64;

    typedef enum logic [2:0] {
        PH_COOKIE = 3'd0,
        PH_CODE   = 3'd1,
        PH_LEN    = 3'd2,
        PH_VALUE  = 3'd3,
        PH_DONE   = 3'd4,
        PH_SKIP   = 3'd5
    } t_phase;

    typedef enum logic [3:0] {
        K_DNS       = 4'd0,
        K_LEASE     = 4'd1,
        K_RENEWAL   = 4'd2,
        K_ROUTER    = 4'd3,
        K_SERVER    = 4'd4,
        K_MASK      = 4'd5,
        K_NAME_BYTE = 4'd6,
        K_DONE      = 4'd7,
        K_BAD       = 4'd8,
        K_TRUNC     = 4'd9
    } t_kind;

    localparam logic [7:0] OPT_PAD     = 8'd0;
    localparam logic [7:0] OPT_MASK    = 8'd1;
    localparam logic [7:0] OPT_ROUTER  = 8'd3;
    localparam logic [7:0] OPT_DNS     = 8'd6;
    localparam logic [7:0] OPT_NAME    = 8'd15;
    localparam logic [7:0] OPT_LEASE   = 8'd51;
    localparam logic [7:0] OPT_SERVER  = 8'd54;
    localparam logic [7:0] OPT_RENEWAL = 8'd58;
    localparam logic [7:0] OPT_END     = 8'hff;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] value;
        logic [5:0]  name_pos;
        logic        last_result;
    } t_result;

endpackage

// File: rtl/core/dop_if.sv
// Byte and result channel interfaces of the DHCP options parser.
interface dop_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       final_byte;

    modport source (output valid, output opt_byte, output final_byte, input ready);
    modport sink   (input valid, input opt_byte, input final_byte, output ready);
endinterface

interface dop_res_if
    import dop_pkg::*;
();
    logic        valid;
    logic        ready;
    t_kind       kind;
    logic [31:0] value;
    logic [5:0]  name_pos;
    logic        last_result;

    modport source (output valid, output kind, output value, output name_pos,
                    output last_result, input ready);
    modport sink   (input valid, input kind, input value, input name_pos,
                    input last_result, output ready);
endinterface

// File: rtl/core/dhcp_option_parser_core.sv
// DHCP options area parser: byte-wise TLV walk with a four-entry result queue.
//
//   channel   dir  payload                                   handshake
//   i_byte    in   opt_byte[7:0], final_byte                 valid/ready
//   o_res     out  kind[3:0], value[31:0], name_pos[5:0],    valid/ready
//                  last_result
//
// One byte per cycle: the parser updates its state and writes zero, one or two
// results into the queue in the cycle the byte is accepted.
// Results leave the queue one per cycle; the first one is visible the cycle after.
// i_byte.ready is high while the queue holds at most two results, so a stalled
// output side backs up into the byte channel once three or four results wait.
// Synchronous active-low reset clears parser state and empties the queue.
module dhcp_option_parser_core
    import dop_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    dop_byte_if.sink i_byte,
    dop_res_if.source o_res
);

`include "dhcp_option_parser_core_assert.svh"

    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);
    localparam int NAME_LIM = (NAME_BYTES < 64) ? NAME_BYTES : 64;

    localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};

    // parser state
    t_phase      r_phase,     n_phase;
    logic [1:0]  r_cookie_idx, n_cookie_idx;
    logic [7:0]  r_code,      n_code;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [31:0] r_acc,       n_acc;
    logic [2:0]  r_acc_cnt,   n_acc_cnt;
    logic [31:0] r_lease,     n_lease;
    logic [31:0] r_renewal,   n_renewal;
    logic [6:0]  r_name_cnt,  n_name_cnt;

    // result queue
    t_result          r_queue [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;

    logic     in_fire;
    logic     out_fire;
    logic     main_v;
    t_result  main_res;
    logic     trunc_v;
    logic     closed;
    logic     fin_v;
    t_kind    fin_kind;
    logic [31:0] fin_val;
    logic     finish;
    logic [1:0]  push_n;
    t_result  slot0;
    t_result  slot1;

    assign i_byte.ready = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign in_fire      = i_byte.valid && i_byte.ready;
    assign o_res.valid  = (r_count != '0);
    assign out_fire     = o_res.valid && o_res.ready;

    assign o_res.kind        = r_queue[r_rd_ptr].kind;
    assign o_res.value       = r_queue[r_rd_ptr].value;
    assign o_res.name_pos    = r_queue[r_rd_ptr].name_pos;
    assign o_res.last_result = r_queue[r_rd_ptr].last_result;

    always_comb begin
        logic [7:0] b;
        b = i_byte.opt_byte;

        n_phase      = r_phase;
        n_cookie_idx = r_cookie_idx;
        n_code       = r_code;
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_acc_cnt    = r_acc_cnt;
        n_lease      = r_lease;
        n_renewal    = r_renewal;
        n_name_cnt   = r_name_cnt;
        main_v       = 1'b0;
        main_res     = '{kind: K_DNS, value: 32'd0, name_pos: 6'd0, last_result: 1'b0};
        closed       = 1'b0;
        finish       = 1'b0;

        case (r_phase)
            PH_COOKIE: begin
                if (b != COOKIE[r_cookie_idx]) begin
                    main_v   = 1'b1;
                    main_res = '{kind: K_BAD, value: 32'd0, name_pos: 6'd0,
                                 last_result: 1'b1};
                    n_phase  = PH_SKIP;
                    closed   = 1'b1;
                end else if (r_cookie_idx == 2'd3) begin
                    n_phase = PH_CODE;
                end else begin
                    n_cookie_idx = r_cookie_idx + 2'd1;
                end
            end
            PH_CODE: begin
                if (b == OPT_END) begin
                    main_v   = 1'b1;
                    main_res = '{kind: K_DONE,
                                 value: (r_renewal != 32'd0) ? r_renewal
                                                             : {1'b0, r_lease[31:1]},
                                 name_pos: 6'd0, last_result: 1'b1};
                    n_phase  = PH_DONE;
                    closed   = 1'b1;
                end else if (b != OPT_PAD) begin
                    n_code  = b;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_bytes_left = b;
                n_acc        = 32'd0;
                n_acc_cnt    = 3'd0;
                if (r_code == OPT_NAME) begin
                    n_name_cnt = 7'd0;
                end
                if (b == 8'd0) begin
                    finish = 1'b1;
                end else begin
                    n_phase = PH_VALUE;
                end
            end
            PH_VALUE: begin
                if (r_acc_cnt < 3'd4) begin
                    n_acc     = {r_acc[23:0], b};
                    n_acc_cnt = r_acc_cnt + 3'd1;
                end
                if (r_code == OPT_NAME) begin
                    if (r_name_cnt < 7'(NAME_LIM)) begin
                        main_v   = 1'b1;
                        main_res = '{kind: K_NAME_BYTE, value: 32'(b),
                                     name_pos: r_name_cnt[5:0], last_result: 1'b0};
                    end
                    if (r_name_cnt != 7'd127) begin
                        n_name_cnt = r_name_cnt + 7'd1;
                    end
                end
                n_bytes_left = r_bytes_left - 8'd1;
                if (r_bytes_left == 8'd1) begin
                    finish = 1'b1;
                end
            end
            PH_DONE, PH_SKIP: begin
                closed = 1'b1;
            end
            default: begin
                n_phase = PH_SKIP;
                closed  = 1'b1;
            end
        endcase

        // left-align a short value, then map the option code to a result kind
        case (n_acc_cnt)
            3'd1:    fin_val = {n_acc[7:0], 24'd0};
            3'd2:    fin_val = {n_acc[15:0], 16'd0};
            3'd3:    fin_val = {n_acc[23:0], 8'd0};
            3'd4:    fin_val = n_acc;
            default: fin_val = 32'd0;
        endcase
        fin_v    = 1'b1;
        fin_kind = K_DNS;
        case (r_code)
            OPT_DNS:     fin_kind = K_DNS;
            OPT_LEASE:   fin_kind = K_LEASE;
            OPT_RENEWAL: fin_kind = K_RENEWAL;
            OPT_ROUTER:  fin_kind = K_ROUTER;
            OPT_SERVER:  fin_kind = K_SERVER;
            OPT_MASK:    fin_kind = K_MASK;
            default:     fin_v    = 1'b0;
        endcase
        if (finish) begin
            n_phase = PH_CODE;
            if (r_code == OPT_LEASE) begin
                n_lease = fin_val;
            end
            if (r_code == OPT_RENEWAL) begin
                n_renewal = fin_val;
            end
            if (fin_v) begin
                main_v   = 1'b1;
                main_res = '{kind: fin_kind, value: fin_val, name_pos: 6'd0,
                             last_result: 1'b0};
            end
        end

        trunc_v = i_byte.final_byte && !closed;
        if (i_byte.final_byte) begin
            n_phase      = PH_COOKIE;
            n_cookie_idx = 2'd0;
            n_code       = 8'd0;
            n_bytes_left = 8'd0;
            n_acc        = 32'd0;
            n_acc_cnt    = 3'd0;
            n_lease      = 32'd0;
            n_renewal    = 32'd0;
            n_name_cnt   = 7'd0;
        end

        // option result first, then the truncation marker
        slot1 = '{kind: K_TRUNC, value: 32'd0, name_pos: 6'd0, last_result: 1'b1};
        if (main_v) begin
            slot0  = main_res;
            push_n = trunc_v ? 2'd2 : 2'd1;
        end else begin
            slot0  = slot1;
            push_n = trunc_v ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_COOKIE;
            r_cookie_idx <= 2'd0;
            r_code       <= 8'd0;
            r_bytes_left <= 8'd0;
            r_acc        <= 32'd0;
            r_acc_cnt    <= 3'd0;
            r_lease      <= 32'd0;
            r_renewal    <= 32'd0;
            r_name_cnt   <= 7'd0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_cookie_idx <= n_cookie_idx;
            r_code       <= n_code;
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_acc_cnt    <= n_acc_cnt;
            r_lease      <= n_lease;
            r_renewal    <= n_renewal;
            r_name_cnt   <= n_name_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && (push_n != 2'd0)) begin
            r_queue[r_wr_ptr] <= slot0;
        end
        if (in_fire && (push_n == 2'd2)) begin
            r_queue[r_wr_ptr + QAW'(1)] <= slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_wr_ptr <= r_wr_ptr + QAW'(push_n);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            r_count <= r_count + (QAW+1)'(in_fire ? push_n : 2'd0)
                               - (QAW+1)'(out_fire);
        end
    end

    `DOP_ASSERT_IMP(a_queue_bound, 1'b1, r_count <= (QAW+1)'(QDEPTH))
    `DOP_ASSERT_IMP(a_room_for_two, in_fire, r_count <= (QAW+1)'(QDEPTH - 2))
    `DOP_ASSERT_IMP(a_value_pending, r_phase == PH_VALUE, r_bytes_left != 8'd0)
    `DOP_ASSERT_NXT(a_final_rearms, in_fire && i_byte.final_byte,
                    r_phase == PH_COOKIE && r_lease == 32'd0 && r_renewal == 32'd0)

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the DHCP options parser core, checked against its own byte predictor.
module tb_top
    import dop_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ITEMS        = 1150;
    localparam int CALM_FROM      = 1000;
    localparam int WATCHDOG_LIMIT = 500;

    localparam logic [7:0] COOKIE [4] = '{8'h63, 8'h82, 8'h53, 8'h63};
    localparam logic [7:0] OPT_CODES [8] = '{OPT_PAD, OPT_MASK, OPT_ROUTER, OPT_DNS,
                                             OPT_NAME, OPT_LEASE, OPT_SERVER, OPT_RENEWAL};

    typedef struct packed {
        logic [7:0] opt_byte;
        logic       final_byte;
        logic       typed;
        t_result    want;
    } t_stim_row;

    localparam t_result NO_RES = '{K_DNS, 32'd0, 6'd0, 1'b0};

    // Directed packets: bad cookie, full option walk with end and trailer, truncated cookie.
    localparam t_stim_row DIRECTED [28] = '{
        '{8'h00,       1'b1, 1'b1, '{K_BAD, 32'd0, 6'd0, 1'b1}},
        '{COOKIE[0],   1'b0, 1'b0, NO_RES},
        '{COOKIE[1],   1'b0, 1'b0, NO_RES},
        '{COOKIE[2],   1'b0, 1'b0, NO_RES},
        '{COOKIE[3],   1'b0, 1'b0, NO_RES},
        '{OPT_PAD,     1'b0, 1'b0, NO_RES},
        '{OPT_LEASE,   1'b0, 1'b0, NO_RES},
        '{8'd4,        1'b0, 1'b0, NO_RES},
        '{8'hff,       1'b0, 1'b0, NO_RES},
        '{8'hff,       1'b0, 1'b0, NO_RES},
        '{8'hff,       1'b0, 1'b0, NO_RES},
        '{8'hff,       1'b0, 1'b1, '{K_LEASE, 32'hffff_ffff, 6'd0, 1'b0}},
        '{OPT_DNS,     1'b0, 1'b0, NO_RES},
        '{8'd0,        1'b0, 1'b0, NO_RES},
        '{OPT_ROUTER,  1'b0, 1'b0, NO_RES},
        '{8'd0,        1'b0, 1'b0, NO_RES},
        '{OPT_SERVER,  1'b0, 1'b0, NO_RES},
        '{8'd0,        1'b0, 1'b0, NO_RES},
        '{OPT_MASK,    1'b0, 1'b0, NO_RES},
        '{8'd0,        1'b0, 1'b0, NO_RES},
        '{OPT_RENEWAL, 1'b0, 1'b0, NO_RES},
        '{8'd0,        1'b0, 1'b0, NO_RES},
        '{OPT_NAME,    1'b0, 1'b0, NO_RES},
        '{8'd1,        1'b0, 1'b0, NO_RES},
        '{8'h41,       1'b0, 1'b0, NO_RES},
        '{OPT_END,     1'b0, 1'b1, '{K_DONE, 32'h7fff_ffff, 6'd0, 1'b1}},
        '{8'h12,       1'b1, 1'b0, NO_RES},
        '{COOKIE[0],   1'b1, 1'b1, '{K_TRUNC, 32'd0, 6'd0, 1'b1}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dop_byte_if byte_if ();
    dop_res_if  res_if ();

    dhcp_option_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Parser shadow state
    t_phase      ph;
    logic [1:0]  ck_idx;
    logic [7:0]  cur_code;
    logic [7:0]  left;
    logic [31:0] acc;
    logic [2:0]  vcnt;
    logic [31:0] lease_v;
    logic [31:0] renew_v;
    logic [6:0]  ncount;

    t_result due_results [$];
    bit      idle_on;
    int      n_errors;
    int      n_live;
    int      n_packets;
    int      n_checked;
    int      kind_seen [10];
    int      stall_left;
    int      quiet_cycles;

    function automatic void clear_parser();
        ph       = PH_COOKIE;
        ck_idx   = 2'd0;
        cur_code = 8'd0;
        left     = 8'd0;
        acc      = 32'd0;
        vcnt     = 3'd0;
        lease_v  = 32'd0;
        renew_v  = 32'd0;
        ncount   = 7'd0;
    endfunction

    // Close the current option: left-align a short value and emit it for known codes.
    function automatic void close_option(ref t_result res [$]);
        logic [31:0] v;
        int          c;
        v = acc;
        c = vcnt;
        while (c < 4) begin
            v = v << 8;
            c++;
        end
        case (cur_code)
            OPT_DNS:     res.push_back(t_result'{K_DNS, v, 6'd0, 1'b0});
            OPT_LEASE: begin
                lease_v = v;
                res.push_back(t_result'{K_LEASE, v, 6'd0, 1'b0});
            end
            OPT_RENEWAL: begin
                renew_v = v;
                res.push_back(t_result'{K_RENEWAL, v, 6'd0, 1'b0});
            end
            OPT_ROUTER:  res.push_back(t_result'{K_ROUTER, v, 6'd0, 1'b0});
            OPT_SERVER:  res.push_back(t_result'{K_SERVER, v, 6'd0, 1'b0});
            OPT_MASK:    res.push_back(t_result'{K_MASK, v, 6'd0, 1'b0});
            default: ;
        endcase
        ph = PH_CODE;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic fin,
                                       ref t_result res [$]);
        bit          closed;
        logic [31:0] eff;
        closed = 1'b0;
        res.delete();
        case (ph)
            PH_COOKIE: begin
                if (b != COOKIE[ck_idx]) begin
                    res.push_back(t_result'{K_BAD, 32'd0, 6'd0, 1'b1});
                    ph     = PH_SKIP;
                    closed = 1'b1;
                end else if (ck_idx == 2'd3) begin
                    ph = PH_CODE;
                end else begin
                    ck_idx = ck_idx + 2'd1;
                end
            end
            PH_CODE: begin
                if (b == OPT_END) begin
                    eff = (renew_v != 32'd0) ? renew_v : (lease_v >> 1);
                    res.push_back(t_result'{K_DONE, eff, 6'd0, 1'b1});
                    ph     = PH_DONE;
                    closed = 1'b1;
                end else if (b != OPT_PAD) begin
                    cur_code = b;
                    ph       = PH_LEN;
                end
            end
            PH_LEN: begin
                left = b;
                acc  = 32'd0;
                vcnt = 3'd0;
                if (cur_code == OPT_NAME) ncount = 7'd0;
                if (b == 8'd0) close_option(res);
                else ph = PH_VALUE;
            end
            PH_VALUE: begin
                if (vcnt < 3'd4) begin
                    acc  = {acc[23:0], b};
                    vcnt = vcnt + 3'd1;
                end
                if (cur_code == OPT_NAME) begin
                    if (ncount < NAME_BYTES && ncount < 7'd64)
                        res.push_back(t_result'{K_NAME_BYTE, {24'd0, b}, ncount[5:0], 1'b0});
                    if (ncount < 7'd127) ncount = ncount + 7'd1;
                end
                left = left - 8'd1;
                if (left == 8'd0) close_option(res);
            end
            default: closed = 1'b1;
        endcase
        if (fin) begin
            if (!closed) res.push_back(t_result'{K_TRUNC, 32'd0, 6'd0, 1'b1});
            clear_parser();
        end
    endfunction

    // Present one byte, hold it until accepted, then queue what it should produce.
    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input t_result want);
        int      gap;
        t_result res [$];
        gap = (idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.opt_byte   <= b;
        byte_if.final_byte <= fin;
        do @(posedge i_clk); while (!byte_if.ready);
        if (ph != PH_DONE && ph != PH_SKIP) n_live++;
        parse_byte(b, fin, res);
        if (typed) due_results.push_back(want);
        else foreach (res[i]) due_results.push_back(res[i]);
        if (fin) n_packets++;
    endtask

    // Result side: check each transaction, then stall in random bursts.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_checked++;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d value %h", res_if.kind, res_if.value);
                n_errors++;
            end else begin
                want = due_results.pop_front();
                kind_seen[want.kind]++;
                if (res_if.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
                    n_errors++;
                end
                if (res_if.value !== want.value) begin
                    $error("value: expected %h, got %h", want.value, res_if.value);
                    n_errors++;
                end
                if (res_if.name_pos !== want.name_pos) begin
                    $error("name_pos: expected %0d, got %0d", want.name_pos, res_if.name_pos);
                    n_errors++;
                end
                if (res_if.last_result !== want.last_result) begin
                    $error("last_result: expected %0d, got %0d",
                           want.last_result, res_if.last_result);
                    n_errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 9);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("dhcp_option_parser_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [7:0] pkt [$];
        logic [7:0] code;
        logic [7:0] bad;
        int         sel;
        int         nopt;
        int         len;
        int         cut;
        bit         paused;
        i_rst_n            <= 1'b0;
        byte_if.valid      <= 1'b0;
        byte_if.opt_byte   <= 8'd0;
        byte_if.final_byte <= 1'b0;
        idle_on    = 1'b1;
        n_errors   = 0;
        n_live     = 0;
        n_packets  = 0;
        n_checked  = 0;
        stall_left = 0;
        paused     = 1'b0;
        foreach (kind_seen[k]) kind_seen[k] = 0;
        clear_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].opt_byte, DIRECTED[i].final_byte,
                      DIRECTED[i].typed, DIRECTED[i].want);

        while (n_live < N_ITEMS) begin
            if (!paused && n_live >= N_ITEMS / 2) begin
                // hold the byte side until the result queue drains
                paused = 1'b1;
                byte_if.valid <= 1'b0;
                while (due_results.size() != 0) @(posedge i_clk);
            end
            idle_on = (n_live < CALM_FROM) && ($urandom_range(0, 3) != 0);
            pkt.delete();
            sel = $urandom_range(0, 19);
            if (sel < 2) begin
                // cookie broken at a random position
                cut = $urandom_range(0, 3);
                for (int i = 0; i < cut; i++) pkt.push_back(COOKIE[i]);
                bad = 8'($urandom);
                if (bad == COOKIE[cut]) bad = ~bad;
                pkt.push_back(bad);
                len = $urandom_range(0, 5);
                repeat (len) pkt.push_back(8'($urandom));
            end else if (sel == 2) begin
                len = $urandom_range(1, 12);
                repeat (len) pkt.push_back(8'($urandom));
            end else begin
                foreach (COOKIE[i]) pkt.push_back(COOKIE[i]);
                nopt = $urandom_range(0, 6);
                repeat (nopt) begin
                    sel  = $urandom_range(0, 8);
                    code = (sel == 8) ? 8'($urandom_range(1, 254)) : OPT_CODES[sel];
                    pkt.push_back(code);
                    if (code != OPT_PAD) begin
                        sel = $urandom_range(0, 15);
                        if (sel == 0) len = $urandom_range(60, 255);
                        else if (sel < 4) len = $urandom_range(5, 12);
                        else len = $urandom_range(0, 4);
                        pkt.push_back(8'(len));
                        repeat (len) begin
                            sel = $urandom_range(0, 9);
                            pkt.push_back(sel == 0 ? 8'h00 : sel == 1 ? 8'hff : 8'($urandom));
                        end
                    end
                end
                if ($urandom_range(0, 7) == 0) begin
                    // end the packet early at a random byte
                    cut = $urandom_range(1, pkt.size());
                    while (pkt.size() > cut) void'(pkt.pop_back());
                end else begin
                    pkt.push_back(OPT_END);
                    len = $urandom_range(0, 3);
                    repeat (len) pkt.push_back(8'($urandom));
                end
            end
            foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, NO_RES);
        end
        byte_if.valid <= 1'b0;
        idle_on = 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d parsed bytes in %0d packets, %0d results checked", n_live, n_packets,
                 n_checked);
        $display("name bytes %0d, done %0d, bad cookie %0d, truncated %0d, option values %0d",
                 kind_seen[K_NAME_BYTE], kind_seen[K_DONE], kind_seen[K_BAD],
                 kind_seen[K_TRUNC], n_checked - kind_seen[K_NAME_BYTE] - kind_seen[K_DONE]
                 - kind_seen[K_BAD] - kind_seen[K_TRUNC]);
        if (n_errors == 0) begin
            $display("dhcp_option_parser_core: match");
        end else begin
            $display("dhcp_option_parser_core: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dop_pkg.sv
rtl/core/dop_if.sv
rtl/core/dhcp_option_parser_core.sv
test/tb_top.sv
